[rtl/core/ddpp_pkg.sv]
// Shared types, codes and decode functions for the display packet parser.
package ddpp_pkg;

    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] END_MARK   = 8'hAB;
    localparam logic [7:0] CHAR_V     = 8'h56;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] ID_VERSION = 8'h01;
    localparam logic [7:0] ID_ACK_A   = 8'h12;
    localparam logic [7:0] ID_ACK_B   = 8'h13;
    localparam logic [7:0] ID_DISPLAY = 8'h31;
    localparam logic [7:0] ID_PWR_OFF = 8'h32;
    localparam logic [7:0] ID_PWR_ON  = 8'h33;
    localparam logic [7:0] ID_ACK_HI  = 8'h36;
    localparam logic [7:0] ID_ACK_C   = 8'h39;
    localparam logic [7:0] ID_ALERT   = 8'h43;

    // Byte positions (counted from zero) that gate field capture and the length rules
    localparam logic [7:0] POS_START   = 8'd0;
    localparam logic [7:0] POS_ID      = 8'd3;
    localparam logic [7:0] POS_PL_LO   = 8'd5;
    localparam logic [7:0] POS_PL_HI   = 8'd12;
    localparam logic [7:0] POS_ACK_MIN = 8'd6;
    localparam logic [7:0] POS_STD_MIN = 8'd7;
    localparam logic [7:0] POS_VER_MIN = 8'd11;
    localparam logic [7:0] POS_DSP_MIN = 8'd13;
    localparam logic [7:0] POS_MAX     = 8'd255;

    localparam logic [6:0] LETTER_NONE = 7'h00;
    localparam logic [6:0] LETTER_A    = 7'h41;
    localparam logic [6:0] LETTER_LO_L = 7'h6C;
    localparam logic [6:0] LETTER_UP_L = 7'h4C;
    localparam logic [3:0] LASER_BARS  = 4'd6;

    localparam int VER_W = 17;
    localparam logic [VER_W-1:0] W_10000 = 17'd10000;
    localparam logic [VER_W-1:0] W_1000  = 17'd1000;
    localparam logic [VER_W-1:0] W_100   = 17'd100;
    localparam logic [VER_W-1:0] W_10    = 17'd10;

    typedef enum logic [2:0] {
        KIND_REJECT,
        KIND_DISPLAY,
        KIND_ALERT,
        KIND_VERSION,
        KIND_PWR_OFF_ACK,
        KIND_PWR_ON_ACK,
        KIND_OTHER_ACK
    } kind_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DISPLAY,
        ACT_VERSION,
        ACT_PWR_OFF,
        ACT_PWR_ON
    } act_t;

    typedef enum logic [1:0] {
        PWR_UNKNOWN,
        PWR_OFF,
        PWR_ON
    } power_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_A,
        MODE_LO_L,
        MODE_UP_L
    } mode_t;

    // One classified packet on its way from front to back
    typedef struct packed {
        logic            acc;
        kind_t           kind;
        act_t            act;
        logic [7:0][7:0] payload;
    } pkt_rec_t;

    function automatic logic [6:0] seg_to_ascii(input logic [7:0] code);
        logic [6:0] c;
        case (code[6:0])
            7'd6:    c = 7'h31;
            7'd7:    c = 7'h37;
            7'd24:   c = 7'h26;
            7'd28:   c = 7'h75;
            7'd30:   c = 7'h4A;
            7'd56:   c = 7'h4C;
            7'd57:   c = 7'h43;
            7'd62:   c = 7'h55;
            7'd63:   c = 7'h30;
            7'd73:   c = 7'h23;
            7'd79:   c = 7'h33;
            7'd88:   c = 7'h63;
            7'd91:   c = 7'h32;
            7'd94:   c = 7'h64;
            7'd102:  c = 7'h34;
            7'd109:  c = 7'h35;
            7'd111:  c = 7'h39;
            7'd113:  c = 7'h46;
            7'd115:  c = 7'h50;
            7'd119:  c = 7'h41;
            7'd121:  c = 7'h45;
            7'd124:  c = 7'h62;
            7'd125:  c = 7'h36;
            7'd127:  c = 7'h38;
            default: c = 7'h20;
        endcase
        return c;
    endfunction

    // Bands stay in bits 0-3, arrows move from bits 5-7 to bits 4-6
    function automatic logic [6:0] lamp_layout(input logic [7:0] img);
        return {img[7:5], img[3:0]};
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    // Non-digit characters count as zero
    function automatic logic [3:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = c - CHAR_ZERO;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return d[3:0];
        else
            return 4'd0;
    endfunction

endpackage

[rtl/core/ddpp_front.sv]
// Front end: byte counting, field capture and packet classification.
module ddpp_front
    import ddpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  logic     last_byte,
    input  logic [7:0] data_byte,
    output logic     push,
    output pkt_rec_t rec
);

    logic [7:0]      pos_reg, pos_next;
    logic            start_ok_reg;
    logic [7:0]      id_reg;
    logic [7:0][7:0] payload_reg;

    logic            start_ok_now;
    logic [7:0]      id_now;
    logic [7:0][7:0] payload_now;
    logic [7:0]      pl_off;
    logic            is_ack;
    logic            framed;

    assign pl_off = pos_reg - POS_PL_LO;

    // Fold the current byte into the captured fields
    always_comb
    begin
        start_ok_now = start_ok_reg;
        id_now       = id_reg;
        payload_now  = payload_reg;
        if (pos_reg == POS_START)
            start_ok_now = (data_byte == START_MARK);
        if (pos_reg == POS_ID)
            id_now = data_byte;
        if (pos_reg >= POS_PL_LO && pos_reg <= POS_PL_HI)
            payload_now[pl_off[2:0]] = data_byte;
    end

    always_comb
    begin
        if (last_byte)
            pos_next = '0;
        else if (pos_reg != POS_MAX)
            pos_next = pos_reg + 8'd1;
        else
            pos_next = pos_reg;
    end

    assign is_ack = id_now inside {ID_ACK_A, ID_ACK_B, [ID_PWR_OFF:ID_ACK_HI], ID_ACK_C};
    assign framed = start_ok_now && (data_byte == END_MARK) && (pos_reg >= POS_ACK_MIN)
                    && (is_ack || pos_reg >= POS_STD_MIN);

    always_comb
    begin
        rec.acc     = 1'b0;
        rec.kind    = KIND_REJECT;
        rec.act     = ACT_NONE;
        rec.payload = payload_now;
        if (framed)
        begin
            case (id_now)
                ID_DISPLAY:
                begin
                    if (pos_reg >= POS_DSP_MIN)
                    begin
                        rec.acc  = 1'b1;
                        rec.kind = KIND_DISPLAY;
                        rec.act  = ACT_DISPLAY;
                    end
                end
                ID_ALERT:
                begin
                    rec.acc  = 1'b1;
                    rec.kind = KIND_ALERT;
                end
                ID_VERSION:
                begin
                    rec.acc  = 1'b1;
                    rec.kind = KIND_VERSION;
                    if (pos_reg >= POS_VER_MIN && payload_now[1] == CHAR_V)
                        rec.act = ACT_VERSION;
                end
                ID_PWR_OFF:
                begin
                    rec.acc  = 1'b1;
                    rec.kind = KIND_PWR_OFF_ACK;
                    rec.act  = ACT_PWR_OFF;
                end
                ID_PWR_ON:
                begin
                    rec.acc  = 1'b1;
                    rec.kind = KIND_PWR_ON_ACK;
                    rec.act  = ACT_PWR_ON;
                end
                default:
                begin
                    if (is_ack)
                    begin
                        rec.acc  = 1'b1;
                        rec.kind = KIND_OTHER_ACK;
                    end
                end
            endcase
        end
    end

    assign push = take && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            start_ok_reg <= 1'b0;
            id_reg       <= '0;
        end
        else if (take)
        begin
            pos_reg      <= pos_next;
            start_ok_reg <= start_ok_now;
            id_reg       <= id_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            payload_reg <= payload_now;
    end

endmodule

[rtl/core/ddpp_queue.sv]
// Short queue of classified packets between front and back.
module ddpp_queue
    import ddpp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pkt_rec_t rec_in,
    output logic     full,
    input  logic     pop,
    output logic     valid,
    output pkt_rec_t rec_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    pkt_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign valid   = (count_reg != '0);
    assign rec_out = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_ONE;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_ONE;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_ONE;
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= rec_in;
    end

endmodule

[rtl/core/ddpp_back.sv]
// Back end: applies classified packets to the display state and holds the result.
module ddpp_back
    import ddpp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  pkt_rec_t     rec,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         accepted,
    output logic [2:0]   packet_kind,
    output logic [7:0]   bogey_glyph,
    output logic [6:0]   indicator_bits,
    output logic [6:0]   flash_bits,
    output logic         muted,
    output logic [3:0]   main_volume,
    output logic [3:0]   mute_volume,
    output logic [3:0]   signal_bars,
    output logic [6:0]   mode_letter,
    output logic [1:0]   display_power,
    output logic signed [17:0] firmware_version
);

    logic        out_valid_reg;
    logic        acc_reg;
    kind_t       kind_reg;
    logic [7:0]  glyph_reg, glyph_next;
    logic [6:0]  lamp_reg, lamp_next;
    logic [6:0]  blink_reg, blink_next;
    logic        mute_reg, mute_next;
    logic [7:0]  volume_reg, volume_next;
    logic [3:0]  bars_reg, bars_next;
    logic [6:0]  letter_reg, letter_next;
    power_t      power_reg, power_next;
    logic [17:0] version_reg, version_next;

    logic [7:0]       img1, img2, aux1, aux2;
    mode_t            mode;
    logic [VER_W-1:0] ver_sum;

    assign img1 = rec.payload[3];
    assign img2 = rec.payload[4];
    assign aux1 = rec.payload[6];
    assign aux2 = rec.payload[7];
    assign mode = mode_t'(aux1[3:2]);

    // Constant weights only: each product is a few shifted adds
    assign ver_sum = {13'd0, digit_of(rec.payload[2])} * W_10000
                   + {13'd0, digit_of(rec.payload[3])} * W_1000
                   + {13'd0, digit_of(rec.payload[4])} * W_100
                   + {13'd0, digit_of(rec.payload[5])} * W_10
                   + {13'd0, digit_of(rec.payload[6])};

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        glyph_next   = glyph_reg;
        lamp_next    = lamp_reg;
        blink_next   = blink_reg;
        mute_next    = mute_reg;
        volume_next  = volume_reg;
        bars_next    = bars_reg;
        letter_next  = letter_reg;
        power_next   = power_reg;
        version_next = version_reg;
        case (rec.act)
            ACT_DISPLAY:
            begin
                glyph_next  = {rec.payload[0][7], seg_to_ascii(rec.payload[0])};
                lamp_next   = lamp_layout(img1);
                blink_next  = lamp_layout(img1 & ~img2);
                volume_next = aux2;
                mute_next   = img1[4] || (aux2[7:4] == 4'd0);
                bars_next   = img1[0] ? LASER_BARS : popcount8(rec.payload[2]);
                case (mode)
                    MODE_A:    letter_next = LETTER_A;
                    MODE_LO_L: letter_next = LETTER_LO_L;
                    MODE_UP_L: letter_next = LETTER_UP_L;
                    default:   letter_next = LETTER_NONE;
                endcase
            end
            ACT_VERSION: version_next = {1'b0, ver_sum};
            ACT_PWR_OFF: power_next   = PWR_OFF;
            ACT_PWR_ON:  power_next   = PWR_ON;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= 1'b0;
            kind_reg      <= KIND_REJECT;
            glyph_reg     <= '0;
            lamp_reg      <= '0;
            blink_reg     <= '0;
            mute_reg      <= 1'b0;
            volume_reg    <= '0;
            bars_reg      <= '0;
            letter_reg    <= '0;
            power_reg     <= PWR_UNKNOWN;
            version_reg   <= '1;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= rec.acc;
                kind_reg      <= rec.kind;
                glyph_reg     <= glyph_next;
                lamp_reg      <= lamp_next;
                blink_reg     <= blink_next;
                mute_reg      <= mute_next;
                volume_reg    <= volume_next;
                bars_reg      <= bars_next;
                letter_reg    <= letter_next;
                power_reg     <= power_next;
                version_reg   <= version_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // State only moves on a pop, so it doubles as the held result
    assign out_valid        = out_valid_reg;
    assign accepted         = acc_reg;
    assign packet_kind      = kind_reg;
    assign bogey_glyph      = glyph_reg;
    assign indicator_bits   = lamp_reg;
    assign flash_bits       = blink_reg;
    assign muted            = mute_reg;
    assign main_volume      = volume_reg[7:4];
    assign mute_volume      = volume_reg[3:0];
    assign signal_bars      = bars_reg;
    assign mode_letter      = letter_reg;
    assign display_power    = power_reg;
    assign firmware_version = $signed(version_reg);

endmodule

[rtl/core/detector_display_packet_parser_top.sv]
// Top level of the display packet parser: front end, packet queue and back end.
// Throughput: one byte item per cycle while the packet queue is not full; no bubbles between packets.
// Path: the front classifies a packet as its final byte is accepted, the queue
// registers the record, and the back end registers the result on out_valid when it pops it.
// Input stalls only while the packet queue is full, i.e. when results back up.
// Reset (rst_n low, asynchronous) clears the byte counter, queue, output valid
// and display state; firmware_version resets to -1, display_power to unknown.
module detector_display_packet_parser_top
    import ddpp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic [2:0]         packet_kind,
    output logic [7:0]         bogey_glyph,
    output logic [6:0]         indicator_bits,
    output logic [6:0]         flash_bits,
    output logic               muted,
    output logic [3:0]         main_volume,
    output logic [3:0]         mute_volume,
    output logic [3:0]         signal_bars,
    output logic [6:0]         mode_letter,
    output logic [1:0]         display_power,
    output logic signed [17:0] firmware_version
);

    logic     take;
    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    pkt_rec_t front_rec;
    pkt_rec_t back_rec;

    // Hold every byte while the queue is full; a final byte would need a slot
    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;

    // Count positions, capture start, id and payload, classify on the final byte
    ddpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .last_byte (last_byte),
        .data_byte (data_byte),
        .push      (push),
        .rec       (front_rec)
    );

    // Decouple classification from result delivery
    ddpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rec_in  (front_rec),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rec_out (back_rec)
    );

    // Apply the packet to the display state and present the result item
    ddpp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .rec              (back_rec),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .packet_kind      (packet_kind),
        .bogey_glyph      (bogey_glyph),
        .indicator_bits   (indicator_bits),
        .flash_bits       (flash_bits),
        .muted            (muted),
        .main_volume      (main_volume),
        .mute_volume      (mute_volume),
        .signal_bars      (signal_bars),
        .mode_letter      (mode_letter),
        .display_power    (display_power),
        .firmware_version (firmware_version)
    );

endmodule

[rtl/core/ddpp_checker.sv]
// Port-level checks for the display packet parser, bound to the top level.
module ddpp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               accepted,
    input logic [2:0]         packet_kind,
    input logic [6:0]         indicator_bits,
    input logic [6:0]         flash_bits,
    input logic [3:0]         signal_bars,
    input logic [1:0]         display_power,
    input logic signed [17:0] firmware_version
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(packet_kind)
            && $stable(firmware_version) && $stable(accepted))
        else $error("stalled result changed");

    // Only a handled packet carries a non-zero kind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (packet_kind != 3'd0)))
        else $error("accepted and packet kind disagree");

    // Flashing lamps are always a subset of the lit ones
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((flash_bits & ~indicator_bits) == 7'd0))
        else $error("flash bit without lamp");

    // Laser lit forces six bars
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && indicator_bits[0] |-> signal_bars == 4'd6)
        else $error("laser lit but bar count not six");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> display_power != 2'd3)
        else $error("display power code out of range");

endmodule

bind detector_display_packet_parser_top ddpp_checker u_ddpp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .accepted         (accepted),
    .packet_kind      (packet_kind),
    .indicator_bits   (indicator_bits),
    .flash_bits       (flash_bits),
    .signal_bars      (signal_bars),
    .display_power    (display_power),
    .firmware_version (firmware_version)
);
